// ----- src/npdt_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// npdt_pkg
// Shared types, constants, hash helpers and the decimal step for the name/pid directory table.
// -----------------------------------------------------------------------------
package npdt_pkg;

   // table length is 2^SLOT_W - 1, so a slot is a fold of SLOT_W-bit chunks
   localparam int SLOT_W    = 10;
   localparam int TABLE_LEN = (1 << SLOT_W) - 1;
   localparam int HASH_W    = 64;
   localparam int FOLD_N    = (HASH_W + SLOT_W - 1) / SLOT_W;
   localparam int FOLD_W    = SLOT_W + $clog2(FOLD_N);
   localparam int CNT_W     = $clog2(HASH_W);
   localparam int DIGITS    = 20;
   localparam int BCD_W     = 4 * DIGITS;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [7:0]        ASCII_0   = 8'h30;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_LOOKUP   = 2'd1,
      OP_REM_NAME = 2'd2,
      OP_REM_PID  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOTFOUND  = 2'd1,
      ST_PIDTAKEN  = 2'd2,
      ST_NAMETAKEN = 2'd3
   } status_type;

   // One finished request handed from front to back.
   typedef struct packed {
      op_type              op;
      logic [HASH_W-1:0]   nhash;
      logic [HASH_W-1:0]   pid;
   } cmd_type;

   // FNV-1a step: xor byte, multiply by 0x100000001b3 (shift-add form).
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // Hash modulo TABLE_LEN: 2^SLOT_W == 1 mod TABLE_LEN, so sum the chunks,
   // fold the carry bits back in, then one compare and subtract.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [HASH_W-1:0] h);
      logic [FOLD_N*SLOT_W-1:0] x;
      logic [FOLD_W-1:0]        s;
      logic [SLOT_W:0]          f;
      x = (FOLD_N*SLOT_W)'(h);
      s = '0;
      for (int i = 0; i < FOLD_N; i++) begin
         s = s + FOLD_W'(x[SLOT_W*i +: SLOT_W]);
      end
      f = (SLOT_W+1)'(s[SLOT_W-1:0]) + (SLOT_W+1)'(s[FOLD_W-1:SLOT_W]);
      if (f >= (SLOT_W+1)'(TABLE_LEN)) f = f - (SLOT_W+1)'(TABLE_LEN);
      return f[SLOT_W-1:0];
   endfunction

   // One double-dabble step: adjust digits, shift in one binary bit.
   function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] v,
                                                input logic b);
      logic [BCD_W-1:0] t;
      t = v;
      for (int i = 0; i < DIGITS; i++) begin
         if (t[4*i +: 4] >= 4'd5) t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
      return {t[BCD_W-2:0], b};
   endfunction

endpackage
`default_nettype wire

// ----- src/npdt_if.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// npdt_req_if / npdt_rsp_if
// Valid/ready channels for request words and response words.
// -----------------------------------------------------------------------------
interface npdt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  name_byte;
   logic        last;
   logic [63:0] pid;
   modport source (output valid, opcode, name_byte, last, pid, input ready);
   modport sink   (input valid, opcode, name_byte, last, pid, output ready);
endinterface

interface npdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] found_pid;
   modport source (output valid, status, found_pid, input ready);
   modport sink   (input valid, status, found_pid, output ready);
endinterface
`default_nettype wire

// ----- src/name_pid_directory_table.sv -----
`default_nettype none
// Flow: a request ends on its last word, which pushes a command into the queue; the back
//   pops it when idle, then converts the pid, walks digits, reads tables and responds.
// Throughput: name words at 1 per cycle while req_ch.ready is high; the back works on
//   one request at a time, through the 64-step pid to decimal pass and the digit walk.
// Reset: synchronous; a clearing pass of both tables follows, with
//   req_ch.ready held low until it ends.
// -----------------------------------------------------------------------------
// name_pid_directory_table
// Name->owner pid and pid->name slot tables, direct mapped, FNV-1a hashed.
// -----------------------------------------------------------------------------
module name_pid_directory_table (
   input  wire          clock,
   input  wire          reset,
   npdt_req_if.sink     req_ch,
   npdt_rsp_if.source   rsp_ch
);
   // front -> queue
   logic              push_valid;
   npdt_pkg::cmd_type push_data;
   // queue -> back
   logic              q_full, q_valid, q_pop;
   npdt_pkg::cmd_type q_data;
   // front only takes words once tables are clear
   logic              clear_done;

   npdt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (clear_done),
      .q_full     (q_full),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // two-entry queue lets names stream in while back works on a request
   npdt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   npdt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .clear_done (clear_done),
      .rsp        (rsp_ch)
   );
endmodule
`default_nettype wire

// ----- src/npdt_front.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// npdt_front
// Takes request words, folds name bytes into the FNV-1a hash, pushes commands.
// -----------------------------------------------------------------------------
module npdt_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              enable,
   input  wire              q_full,
   npdt_req_if.sink         req,
   output logic             push_valid,
   output npdt_pkg::cmd_type push_data
);
   logic [npdt_pkg::HASH_W-1:0] hash_ff, hash_in, hash_cur;
   logic                        ended_ff, ended_in;
   logic                        take;

   assign req.ready = enable && !q_full;
   assign take      = req.valid && req.ready;

   always_comb begin
      hash_cur = hash_ff;
      if (!ended_ff && req.name_byte != 8'd0) begin
         hash_cur = npdt_pkg::fnv_step(hash_ff, req.name_byte);
      end
      hash_in  = hash_ff;
      ended_in = ended_ff;
      if (take) begin
         if (req.last) begin
            hash_in  = npdt_pkg::FNV_BASIS;
            ended_in = 1'b0;
         end else begin
            hash_in  = hash_cur;
            ended_in = ended_ff || (req.name_byte == 8'd0);
         end
      end
   end

   assign push_valid     = take && req.last;
   assign push_data.op    = npdt_pkg::op_type'(req.opcode);
   assign push_data.nhash = hash_cur;
   assign push_data.pid   = req.pid;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= npdt_pkg::FNV_BASIS;
         ended_ff <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         ended_ff <= ended_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/npdt_queue.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// npdt_queue
// Short command FIFO between front and back.
// -----------------------------------------------------------------------------
module npdt_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  npdt_pkg::cmd_type push_data,
   input  wire               pop,
   output logic              full,
   output logic              valid,
   output npdt_pkg::cmd_type pop_data
);
   npdt_pkg::cmd_type             mem_ff [npdt_pkg::Q_DEPTH];
   logic [npdt_pkg::Q_PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [npdt_pkg::Q_PTR_W:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == (npdt_pkg::Q_PTR_W+1)'(npdt_pkg::Q_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (npdt_pkg::Q_PTR_W+1)'(push) - (npdt_pkg::Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/npdt_back.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// npdt_back
// Computes slots, reads and updates both tables, drives the response word.
// -----------------------------------------------------------------------------
module npdt_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               q_valid,
   input  npdt_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              clear_done,
   npdt_rsp_if.source        rsp
);
   localparam int SW = npdt_pkg::SLOT_W;
   localparam int HW = npdt_pkg::HASH_W;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_CALC  = 8'b00000100,
      S_DIG   = 8'b00001000,
      S_RD    = 8'b00010000,
      S_RD2   = 8'b00100000,
      S_RD3   = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   // tables
   logic [HW-1:0] owner_mem [npdt_pkg::TABLE_LEN];
   logic [SW-1:0] slot_mem  [npdt_pkg::TABLE_LEN];

   state_type                  state_ff, state_in;
   npdt_pkg::cmd_type          cmd_ff, cmd_in;
   logic [npdt_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]              clr_ff, clr_in;
   logic [HW-1:0]              psh_ff, psh_in, phash_ff, phash_in;
   logic [npdt_pkg::BCD_W-1:0] bcd_ff, bcd_in;
   logic [SW-1:0]              nmod_ff, nmod_in, pmod_ff, pmod_in;
   logic [HW-1:0]              own_rd_ff, own_n_ff, own_n_in;
   logic [SW-1:0]              slt_rd_ff, stored_ff, stored_in;
   npdt_pkg::status_type       status_ff, status_in;
   logic [HW-1:0]              found_ff, found_in;
   logic [SW-1:0]              own_raddr, slt_raddr;
   logic                       own_we, slt_we;
   logic [SW-1:0]              own_waddr, slt_waddr;
   logic [HW-1:0]              own_wdata;
   logic [SW-1:0]              slt_wdata;
   logic                       pid_zero, stored_ok;

   assign clear_done    = (state_ff != S_CLEAR);
   assign q_pop         = (state_ff == S_IDLE) && q_valid;
   assign rsp.valid     = (state_ff == S_OUT);
   assign rsp.status    = status_ff;
   assign rsp.found_pid = found_ff;

   assign pid_zero  = (cmd_ff.pid == '0);
   assign stored_ok = (stored_ff != '0) &&
                      ({1'b0, stored_ff} < (SW+1)'(npdt_pkg::TABLE_LEN));

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      psh_in    = psh_ff;
      phash_in  = phash_ff;
      bcd_in    = bcd_ff;
      nmod_in   = nmod_ff;
      pmod_in   = pmod_ff;
      own_n_in  = own_n_ff;
      stored_in = stored_ff;
      status_in = status_ff;
      found_in  = found_ff;
      own_raddr = nmod_ff;
      slt_raddr = pmod_ff;
      own_we    = 1'b0;
      slt_we    = 1'b0;
      own_waddr = nmod_ff;
      slt_waddr = pmod_ff;
      own_wdata = '0;
      slt_wdata = '0;

      unique case (state_ff)
         S_CLEAR: begin
            own_we    = 1'b1;
            slt_we    = 1'b1;
            own_waddr = clr_ff;
            slt_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == SW'(npdt_pkg::TABLE_LEN - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_data;
               psh_in   = q_data.pid;
               bcd_in   = '0;
               cnt_in   = '0;
               phash_in = npdt_pkg::FNV_BASIS;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            // pid to decimal, one bit per cycle
            bcd_in  = npdt_pkg::dd_step(bcd_ff, psh_ff[HW-1]);
            psh_in  = {psh_ff[HW-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == '1) state_in = S_DIG;
         end
         S_DIG: begin
            // digits least significant first, stop at leading zeros
            if (bcd_ff == '0) begin
               nmod_in  = npdt_pkg::slot_of(cmd_ff.nhash);
               pmod_in  = npdt_pkg::slot_of(phash_ff);
               state_in = S_RD;
            end else begin
               phash_in = npdt_pkg::fnv_step(phash_ff,
                                             {4'd0, bcd_ff[3:0]} + npdt_pkg::ASCII_0);
               bcd_in   = bcd_ff >> 4;
            end
         end
         S_RD: begin
            state_in = S_RD2;
         end
         S_RD2: begin
            own_n_in  = own_rd_ff;
            stored_in = slt_rd_ff;
            own_raddr = slt_rd_ff;
            state_in  = S_RD3;
         end
         S_RD3: begin
            // own_rd_ff holds owner of the stored name slot
            status_in = npdt_pkg::ST_NOTFOUND;
            found_in  = '0;
            unique case (cmd_ff.op)
               npdt_pkg::OP_ADD: begin
                  if (!pid_zero) begin
                     if (stored_ff != '0) begin
                        status_in = npdt_pkg::ST_PIDTAKEN;
                     end else if (own_n_ff != '0) begin
                        status_in = npdt_pkg::ST_NAMETAKEN;
                     end else begin
                        own_we    = 1'b1;
                        own_wdata = cmd_ff.pid;
                        slt_we    = 1'b1;
                        slt_wdata = nmod_ff;
                        status_in = npdt_pkg::ST_OK;
                     end
                  end
               end
               npdt_pkg::OP_LOOKUP: begin
                  if (own_n_ff != '0) begin
                     found_in  = own_n_ff;
                     status_in = npdt_pkg::ST_OK;
                  end
               end
               npdt_pkg::OP_REM_NAME: begin
                  if (!pid_zero && stored_ff != '0 && own_n_ff == cmd_ff.pid) begin
                     own_we    = 1'b1;
                     slt_we    = 1'b1;
                     status_in = npdt_pkg::ST_OK;
                  end
               end
               npdt_pkg::OP_REM_PID: begin
                  if (!pid_zero && stored_ok && own_rd_ff == cmd_ff.pid) begin
                     own_we    = 1'b1;
                     own_waddr = stored_ff;
                     slt_we    = 1'b1;
                     status_in = npdt_pkg::ST_OK;
                  end
               end
            endcase
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      own_rd_ff <= owner_mem[own_raddr];
      slt_rd_ff <= slot_mem[slt_raddr];
      if (own_we) owner_mem[own_waddr] <= own_wdata;
      if (slt_we) slot_mem[slt_waddr]  <= slt_wdata;
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      cnt_ff    <= cnt_in;
      psh_ff    <= psh_in;
      phash_ff  <= phash_in;
      bcd_ff    <= bcd_in;
      nmod_ff   <= nmod_in;
      pmod_ff   <= pmod_in;
      own_n_ff  <= own_n_in;
      stored_ff <= stored_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/npdt_checker.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// npdt_checker
// Port-level checks for the directory table, bound to the top level.
// -----------------------------------------------------------------------------
module npdt_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_status,
   input wire [63:0] rsp_found_pid
);
   // clearing pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during table clear");

   // found pid only on a successful lookup
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_pid != 64'd0 |-> rsp_status == npdt_pkg::ST_OK)
      else $error("nonzero found pid with failing status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found_pid) && $stable(rsp_status))
      else $error("response word changed while stalled");
endmodule

bind name_pid_directory_table npdt_checker u_npdt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_found_pid (rsp_ch.found_pid)
);
`default_nettype wire
